// ===== rtl/gpm_pkg.sv =====
// Shared types, codes and constants of the gamepad poll master.
`timescale 1ns / 1ps

package gpm_pkg;

	// Default frame length in bytes, start and poll bytes included
	localparam int FRAME_BYTES_DEF = 9;

	// Highest frame byte that the result reports
	localparam int VIEW_LAST = 8;

	localparam logic [7:0] ANALOG_RED_ID = 8'h73;

	// Register reset values
	localparam logic [9:0] HALF_BIT_RST = 10'd50;
	localparam logic [7:0] START_CMD_RST = 8'h01;
	localparam logic [7:0] POLL_CMD_RST = 8'h42;

	// Configuration register indexes
	localparam logic [1:0] CFG_HALF_BIT = 2'd0;
	localparam logic [1:0] CFG_START_CMD = 2'd1;
	localparam logic [1:0] CFG_POLL_CMD = 2'd2;

	// Action codes carried on the input beat
	localparam logic [1:0] ACT_TICK = 2'd0;
	localparam logic [1:0] ACT_POLL = 2'd1;
	localparam logic [1:0] ACT_CHECK = 2'd2;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_HIGH,
		PH_LOW,
		PH_GAP
	} phase_t;

	// Pin levels, completion flag and check-only flag of one tick
	typedef struct packed {
		logic clock_level;
		logic command_level;
		logic select_n;
		logic frame_done;
		logic check_only;
	} pins_t;

	// One result beat
	typedef struct packed {
		logic        clock_level;
		logic        command_level;
		logic        select_n;
		logic        frame_done;
		logic [7:0]  pad_id;
		logic [15:0] buttons;
		logic [4:0]  first_key;
		logic [7:0]  right_x;
		logic [7:0]  right_y;
		logic [7:0]  left_x;
		logic [7:0]  left_y;
		logic        not_analog;
	} item_t;

endpackage

// ===== rtl/gpm_core.sv =====
// Serial sequencer: phase, bit and tick counters, receive shifter and frame store.
`timescale 1ns / 1ps

module gpm_core #(
	parameter int FRAME_BYTES = gpm_pkg::FRAME_BYTES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  logic [1:0]           action,
	input  logic                 data_in,
	input  logic [9:0]           half_bit_ticks,
	input  logic [7:0]           start_command,
	input  logic [7:0]           poll_command,
	output gpm_pkg::pins_t       pins,
	output logic [7:0]           view [1:gpm_pkg::VIEW_LAST]
);

	localparam int BCW = $clog2(FRAME_BYTES);

	gpm_pkg::phase_t  phase_q, phase_d;
	logic [BCW-1:0]   byte_q, byte_d;
	logic [2:0]       bit_q, bit_d;
	logic [9:0]       tick_q, tick_d;
	logic [7:0]       shift_q, shift_d;
	logic             check_q, check_d;
	logic [7:0]       frame_q [FRAME_BYTES];
	logic [7:0]       frame_d [FRAME_BYTES];

	logic             clear;
	logic             wr_en;
	logic [BCW-1:0]   wr_idx;
	logic [7:0]       wr_byte;
	logic             done;
	logic             clk_lvl;
	logic             cmd_lvl;
	logic             run_high;
	logic             run_gap;
	logic [9:0]       half_len;
	logic [10:0]      tick_inc;
	logic [7:0]       cmd_byte;

	assign half_len = (half_bit_ticks == '0) ? 10'd1 : half_bit_ticks;

	// Advance the transaction by one tick
	always_comb begin
		phase_d  = phase_q;
		byte_d   = byte_q;
		bit_d    = bit_q;
		tick_d   = tick_q;
		shift_d  = shift_q;
		check_d  = check_q;
		clear    = 1'b0;
		wr_en    = 1'b0;
		wr_idx   = byte_q;
		wr_byte  = '0;
		run_high = 1'b0;
		run_gap  = 1'b0;
		tick_inc = '0;
		if (step) begin
			if (phase_d == gpm_pkg::PH_IDLE &&
					(action == gpm_pkg::ACT_POLL || action == gpm_pkg::ACT_CHECK)) begin
				clear   = 1'b1;
				check_d = (action == gpm_pkg::ACT_CHECK);
				byte_d  = '0;
				bit_d   = '0;
				tick_d  = '0;
				shift_d = '0;
				phase_d = gpm_pkg::PH_HIGH;
			end
			case (phase_d)
				gpm_pkg::PH_HIGH: begin
					run_high = 1'b1;
				end
				gpm_pkg::PH_LOW: begin
					if (tick_d < half_len) begin
						tick_d  = tick_d + 10'd1;
					end else begin
						// Rising edge: sample the data line
						shift_d = shift_d | (8'(data_in) << bit_d);
						if (bit_d != 3'd7) begin
							bit_d    = bit_d + 3'd1;
							phase_d  = gpm_pkg::PH_HIGH;
							tick_d   = '0;
							run_high = 1'b1;
						end else begin
							if (byte_d != '0) begin
								wr_en   = 1'b1;
								wr_byte = shift_d;
							end
							bit_d   = '0;
							shift_d = '0;
							if (byte_d < BCW'(2)) begin
								if (byte_d == BCW'(1) && check_d) begin
									phase_d = gpm_pkg::PH_IDLE;
									tick_d  = '0;
									byte_d  = '0;
								end else begin
									byte_d   = byte_d + BCW'(1);
									phase_d  = gpm_pkg::PH_HIGH;
									tick_d   = '0;
									run_high = 1'b1;
								end
							end else begin
								phase_d = gpm_pkg::PH_GAP;
								tick_d  = '0;
								run_gap = 1'b1;
							end
						end
					end
				end
				gpm_pkg::PH_GAP: begin
					run_gap = 1'b1;
				end
				default: begin
				end
			endcase
			// Count the clock-high half
			if (run_high) begin
				tick_inc = {1'b0, tick_d} + 11'd1;
				if (tick_inc >= {1'b0, half_len}) begin
					phase_d = gpm_pkg::PH_LOW;
					tick_d  = '0;
				end else begin
					tick_d = tick_inc[9:0];
				end
			end
			// Count the inter-byte gap, close the frame after the last byte
			if (run_gap) begin
				tick_inc = {1'b0, tick_d} + 11'd1;
				if (tick_inc >= {1'b0, half_len}) begin
					if ({1'b0, byte_d} + (BCW+1)'(1) >= (BCW+1)'(FRAME_BYTES)) begin
						phase_d = gpm_pkg::PH_IDLE;
						tick_d  = '0;
						byte_d  = '0;
						bit_d   = '0;
						shift_d = '0;
					end else begin
						byte_d  = byte_d + BCW'(1);
						phase_d = gpm_pkg::PH_HIGH;
						tick_d  = '0;
					end
				end else begin
					tick_d = tick_inc[9:0];
				end
			end
		end
	end

	// Drive the pins from the updated position
	assign cmd_byte = (byte_d == '0) ? start_command : poll_command;

	always_comb begin
		// clock low while a low half still counts; a frame ends on the drop back to idle
		clk_lvl = !(step && phase_q == gpm_pkg::PH_LOW && tick_q < half_len);
		done    = (phase_q != gpm_pkg::PH_IDLE) && (phase_d == gpm_pkg::PH_IDLE);
		if (phase_d == gpm_pkg::PH_IDLE) begin
			cmd_lvl = 1'b1;
		end else if (phase_d != gpm_pkg::PH_GAP && byte_d < BCW'(2)) begin
			cmd_lvl = cmd_byte[bit_d];
		end else begin
			cmd_lvl = 1'b0;
		end
	end

	assign pins.clock_level   = clk_lvl;
	assign pins.command_level = cmd_lvl;
	assign pins.select_n      = (phase_d == gpm_pkg::PH_IDLE);
	assign pins.frame_done    = done;
	assign pins.check_only    = check_d;

	// Next frame contents: cleared on a request, one byte stored per read byte after the start byte
	always_comb begin
		for (int i = 0; i < FRAME_BYTES; i++) begin
			if (clear) begin
				frame_d[i] = '0;
			end else if (wr_en && wr_idx == BCW'(i)) begin
				frame_d[i] = wr_byte;
			end else begin
				frame_d[i] = frame_q[i];
			end
		end
	end

	// Bytes past the frame read as zero
	for (genvar v = 1; v <= gpm_pkg::VIEW_LAST; v++) begin : g_view
		if (v < FRAME_BYTES) begin : g_in
			assign view[v] = frame_d[v];
		end else begin : g_out
			assign view[v] = '0;
		end
	end

	// Hold the sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= gpm_pkg::PH_IDLE;
			byte_q  <= '0;
			bit_q   <= '0;
			tick_q  <= '0;
			shift_q <= '0;
			check_q <= 1'b0;
		end else begin
			phase_q <= phase_d;
			byte_q  <= byte_d;
			bit_q   <= bit_d;
			tick_q  <= tick_d;
			shift_q <= shift_d;
			check_q <= check_d;
		end
	end

	// Frame store
	always_ff @(posedge clk) begin
		for (int i = 0; i < FRAME_BYTES; i++) begin
			frame_q[i] <= frame_d[i];
		end
	end

endmodule

// ===== rtl/gpm_result.sv =====
// Result assembly: pad ID, button word, first pressed key and analog bytes.
`timescale 1ns / 1ps

module gpm_result (
	input  gpm_pkg::pins_t pins,
	input  logic [7:0]     view [1:gpm_pkg::VIEW_LAST],
	output gpm_pkg::item_t item
);

	logic [15:0] keys;
	logic [4:0]  first;
	logic        full;

	assign keys = {view[4], view[3]};
	assign full = pins.frame_done && !pins.check_only;

	// Find the lowest clear button bit
	always_comb begin
		first = '0;
		for (int i = 15; i >= 0; i--) begin
			if (!keys[i]) begin
				first = 5'(i + 1);
			end
		end
	end

	// Zero the result fields unless a frame completes; buttons, key and analog bytes also stay zero on a check-only frame
	always_comb begin
		item.clock_level   = pins.clock_level;
		item.command_level = pins.command_level;
		item.select_n      = pins.select_n;
		item.frame_done    = pins.frame_done;
		item.pad_id        = pins.frame_done ? view[1] : '0;
		item.not_analog    = pins.frame_done && (view[1] != gpm_pkg::ANALOG_RED_ID);
		item.buttons       = full ? keys : '0;
		item.first_key     = full ? first : '0;
		item.right_x       = full ? view[5] : '0;
		item.right_y       = full ? view[6] : '0;
		item.left_x        = full ? view[7] : '0;
		item.left_y        = full ? view[8] : '0;
	end

endmodule

// ===== rtl/gpm_obuf.sv =====
// Output register with a skid stage that parks an input beat while the output is stalled.
`timescale 1ns / 1ps

module gpm_obuf (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  gpm_pkg::item_t in_item,
	output logic           out_valid,
	input  logic           out_ready,
	output gpm_pkg::item_t out_item
);

	logic           out_valid_q;
	logic           skid_valid_q;
	gpm_pkg::item_t out_item_q;
	gpm_pkg::item_t skid_item_q;
	logic           take;
	logic           put;

	assign in_ready  = !skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;
	assign take      = out_valid_q && out_ready;
	assign put       = in_valid && !skid_valid_q;

	// Valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (take) begin
				if (skid_valid_q) begin
					skid_valid_q <= 1'b0;
				end else begin
					out_valid_q <= put;
				end
			end else if (!out_valid_q) begin
				out_valid_q <= put;
			end else if (put) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	// Payload: refill the output from the skid first, park a beat when stalled
	always_ff @(posedge clk) begin
		if (take && skid_valid_q) begin
			out_item_q <= skid_item_q;
		end else if ((take || !out_valid_q) && put) begin
			out_item_q <= in_item;
		end else if (out_valid_q && !take && put) begin
			skid_item_q <= in_item;
		end
	end

endmodule

// ===== rtl/gamepad_poll_master.sv =====
// Gamepad poll master: serial poll sequencer with streaming tick input and result output.
// A tick beat's result is registered in the output register, or in the skid when stalled.
// Throughput: one beat per cycle if the skid is free; each steps the sequencer by one tick.
// A two-entry output buffer (register plus skid) absorbs output stalls without losing beats.
// Reset: asynchronous, active low; sequencer idles (select high, clock high) and registers
// return to 50 ticks per half bit, start byte 0x01, poll byte 0x42.
`timescale 1ns / 1ps

module gamepad_poll_master #(
	parameter int FRAME_BYTES = gpm_pkg::FRAME_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// Tick beats
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [0] data_in, [7:1] zero
	input  logic [1:0]  s_tuser,   // [1:0] action
	// Result beats
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,   // [0] clock_level, [1] command_level, [2] select_n,
	                               // [10:3] pad_id, [26:11] buttons, [31:27] first_key,
	                               // [39:32] right_x, [47:40] right_y, [55:48] left_x,
	                               // [63:56] left_y, [64] not_analog, [71:65] zero
	output logic        m_tlast,   // frame_done
	// Configuration writes
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [9:0]  cfg_wdata
);

	logic [9:0]     half_bit_q;
	logic [7:0]     start_cmd_q;
	logic [7:0]     poll_cmd_q;
	logic           step;
	gpm_pkg::pins_t pins;
	logic [7:0]     view [1:gpm_pkg::VIEW_LAST];
	gpm_pkg::item_t item;
	gpm_pkg::item_t res;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_bit_q  <= gpm_pkg::HALF_BIT_RST;
			start_cmd_q <= gpm_pkg::START_CMD_RST;
			poll_cmd_q  <= gpm_pkg::POLL_CMD_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				gpm_pkg::CFG_HALF_BIT:  half_bit_q  <= cfg_wdata;
				gpm_pkg::CFG_START_CMD: start_cmd_q <= cfg_wdata[7:0];
				gpm_pkg::CFG_POLL_CMD:  poll_cmd_q  <= cfg_wdata[7:0];
				default: begin
				end
			endcase
		end
	end

	assign step = s_tvalid && s_tready;

	gpm_core #(
		.FRAME_BYTES(FRAME_BYTES)
	) u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (step),
		.action        (s_tuser),
		.data_in       (s_tdata[0]),
		.half_bit_ticks(half_bit_q),
		.start_command (start_cmd_q),
		.poll_command  (poll_cmd_q),
		.pins          (pins),
		.view          (view)
	);

	gpm_result u_result (
		.pins(pins),
		.view(view),
		.item(item)
	);

	gpm_obuf u_obuf (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (step),
		.in_ready (s_tready),
		.in_item  (item),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_item (res)
	);

	// Pack the result beat
	assign m_tdata = {7'd0, res.not_analog, res.left_y, res.left_x, res.right_y, res.right_x,
		res.first_key, res.buttons, res.pad_id, res.select_n, res.command_level,
		res.clock_level};
	assign m_tlast = res.frame_done;

	// A finished frame always releases select
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tdata[2])
		else $error("frame done with select still low");

	// The serial clock only drops inside a transaction
	a_clk_sel: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[0] |-> !m_tdata[2])
		else $error("serial clock low while deselected");

	// Input stalls only while the output holds a beat
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("input stalled with empty output");

	// Results are zero outside the finishing tick
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> m_tdata[64:3] == '0)
		else $error("result fields set without frame done");

endmodule
